FILE: hdl/tbpf_pkg.sv
// ----------------------------------------------------------------------------
// tbpf_pkg
// Shared types and constants for the background tile pixel fetch block.
// ----------------------------------------------------------------------------
package tbpf_pkg;

  // Video memory geometry: two byte-wide banks split on address bit 0
  localparam int VRAM_ADDR_W = 16;
  localparam int BANK_ADDR_W = VRAM_ADDR_W - 1;
  localparam int BANK_DEPTH  = 1 << BANK_ADDR_W;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  // Input command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] CFG_MAP_ORIGIN  = 3'd0;
  localparam logic [2:0] CFG_MAP_WIDE    = 3'd1;
  localparam logic [2:0] CFG_MAP_TALL    = 3'd2;
  localparam logic [2:0] CFG_CHAR_ORIGIN = 3'd3;
  localparam logic [2:0] CFG_BIG_TILES   = 3'd4;
  localparam logic [2:0] CFG_SCROLL_X    = 3'd5;
  localparam logic [2:0] CFG_SCROLL_Y    = 3'd6;

  // Map entry fields
  localparam int ENTRY_HFLIP = 14;
  localparam int ENTRY_VFLIP = 15;

  typedef struct packed {
    logic [15:0] map_origin;
    logic        map_wide;
    logic        map_tall;
    logic [15:0] char_origin;
    logic        big_tiles;
    logic [9:0]  scroll_x;
    logic [9:0]  scroll_y;
  } cfg_t;

  // One classified transaction: a byte write or a query with its map address
  typedef struct packed {
    logic        is_query;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [3:0]  tx;
    logic [3:0]  ty;
  } fetch_op_t;

  typedef struct packed {
    logic [QUEUE_CNT_W-1:0] count;
  } queue_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_TILE,
    BK_PIXEL
  } back_state_t;

endpackage

FILE: hdl/tbpf_front.sv
// ----------------------------------------------------------------------------
// tbpf_front
// Classifies incoming transactions and resolves a query's map entry address
// and in-tile position from the scroll and map geometry.
// ----------------------------------------------------------------------------
module tbpf_front (
  input  tbpf_pkg::cfg_t      cfg,
  input  logic                command,
  input  logic [15:0]         mem_address,
  input  logic [7:0]          mem_data,
  input  logic [7:0]          query_x,
  input  logic [7:0]          query_y,
  output tbpf_pkg::fetch_op_t op
);
  import tbpf_pkg::*;

  logic [9:0]  sum_x;
  logic [9:0]  sum_y;
  logic [9:0]  mask_x;
  logic [9:0]  mask_y;
  logic [9:0]  px;
  logic [9:0]  py;
  logic [5:0]  mx;
  logic [5:0]  my;
  logic [1:0]  blk;
  logic [15:0] map_addr;

  // Scroll and wrap to the map size in pixels
  assign sum_x  = {2'b00, query_x} + cfg.scroll_x;
  assign sum_y  = {2'b00, query_y} + cfg.scroll_y + 10'd1;
  assign mask_x = {cfg.map_wide & cfg.big_tiles, cfg.map_wide | cfg.big_tiles, 8'hff};
  assign mask_y = {cfg.map_tall & cfg.big_tiles, cfg.map_tall | cfg.big_tiles, 8'hff};
  assign px     = sum_x & mask_x;
  assign py     = sum_y & mask_y;

  // Tile coordinates and 2 KiB screen block
  assign mx  = cfg.big_tiles ? px[9:4] : px[8:3];
  assign my  = cfg.big_tiles ? py[9:4] : py[8:3];
  assign blk = {1'b0, mx[5]} + (my[5] ? (cfg.map_wide ? 2'd2 : 2'd1) : 2'd0);

  assign map_addr = cfg.map_origin + {3'b000, blk, my[4:0], mx[4:0], 1'b0};

  // Build the queue transaction
  always_comb begin
    op.is_query = (command == CMD_QUERY);
    op.addr     = (command == CMD_QUERY) ? map_addr : mem_address;
    op.data     = mem_data;
    op.tx       = cfg.big_tiles ? px[3:0] : {1'b0, px[2:0]};
    op.ty       = cfg.big_tiles ? py[3:0] : {1'b0, py[2:0]};
  end

endmodule

FILE: hdl/tbpf_queue.sv
// ----------------------------------------------------------------------------
// tbpf_queue
// Short first-in first-out queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module tbpf_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push_valid,
  output logic                    push_ready,
  input  tbpf_pkg::fetch_op_t     push_op,
  output logic                    pop_valid,
  input  logic                    pop_ready,
  output tbpf_pkg::fetch_op_t     pop_op,
  output tbpf_pkg::queue_status_t status
);
  import tbpf_pkg::*;

  fetch_op_t              slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic [QUEUE_PTR_W-1:0] wr_ptr_next;
  logic [QUEUE_PTR_W-1:0] rd_ptr_next;
  logic [QUEUE_CNT_W-1:0] count_next;
  logic                   push;
  logic                   pop;

  assign push_ready   = (count != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign pop_valid    = (count != '0);
  assign push         = push_valid && push_ready;
  assign pop          = pop_valid && pop_ready;
  assign pop_op       = slots[rd_ptr];
  assign status.count = count;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push) begin
      wr_ptr_next = (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  // Store payload
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

endmodule

FILE: hdl/tbpf_back.sv
// ----------------------------------------------------------------------------
// tbpf_back
// Executes queued transactions against the banked video memory: stores
// bytes, and for a query reads the map entry, then the four bit planes, then
// forms the palette index in the output register.
// ----------------------------------------------------------------------------
module tbpf_back (
  input  logic                clk,
  input  logic                rst,
  input  tbpf_pkg::cfg_t      cfg,
  input  logic                op_valid,
  output logic                op_ready,
  input  tbpf_pkg::fetch_op_t op,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [6:0]          palette_index
);
  import tbpf_pkg::*;

  // Video memory banks: even and odd byte addresses
  logic [7:0] vram_even [BANK_DEPTH];
  logic [7:0] vram_odd  [BANK_DEPTH];

  back_state_t state;
  back_state_t state_next;

  // Control decoded per cycle
  logic issue;
  logic load_out;
  logic pop_write;
  logic pop_query;
  logic rd_a_en;
  logic rd_b_en;

  // Read ports and registered read data
  logic [BANK_ADDR_W-1:0] even_a_idx;
  logic [BANK_ADDR_W-1:0] odd_a_idx;
  logic [BANK_ADDR_W-1:0] even_b_idx;
  logic [BANK_ADDR_W-1:0] odd_b_idx;
  logic [15:0]            addr_a;
  logic [7:0]             rd_even_a;
  logic [7:0]             rd_odd_a;
  logic [7:0]             rd_even_b;
  logic [7:0]             rd_odd_b;

  // Per-query payload
  logic       map_lsb;
  logic [3:0] q_tx;
  logic [3:0] q_ty;
  logic [2:0] grp;
  logic [2:0] col;
  logic       plane_lsb;
  logic       out_valid_next;

  // Tile stage datapath
  logic [15:0] entry;
  logic [3:0]  tmask;
  logic [3:0]  tx_f;
  logic [3:0]  ty_f;
  logic [9:0]  tile;
  logic [15:0] char_base;
  logic [15:0] p01;
  logic [15:0] p23;

  // Pixel stage datapath
  logic [7:0] b0;
  logic [7:0] b1;
  logic [7:0] b2;
  logic [7:0] b3;
  logic [2:0] bit_sel;
  logic [3:0] pix;
  logic [6:0] pix_index;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (op_valid && op.is_query) begin
          state_next = BK_TILE;
        end
      end
      BK_TILE: begin
        state_next = BK_PIXEL;
      end
      BK_PIXEL: begin
        if (!out_valid || out_ready) begin
          state_next = (op_valid && op.is_query) ? BK_TILE : BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // Control outputs: a new transaction starts when idle or as the result leaves
  always_comb begin
    load_out  = (state == BK_PIXEL) && (!out_valid || out_ready);
    issue     = (state == BK_IDLE) || load_out;
    op_ready  = issue;
    pop_write = issue && op_valid && !op.is_query;
    pop_query = issue && op_valid && op.is_query;
    rd_a_en   = pop_query || (state == BK_TILE);
    rd_b_en   = (state == BK_TILE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Hold the result until taken
  assign out_valid_next = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid);

  // Assemble map entry and resolve flips and sub-tile
  assign entry = map_lsb ? {rd_even_a, rd_odd_a} : {rd_odd_a, rd_even_a};
  assign tmask = cfg.big_tiles ? 4'hf : 4'h7;
  assign tx_f  = entry[ENTRY_HFLIP] ? (q_tx ^ tmask) : q_tx;
  assign ty_f  = entry[ENTRY_VFLIP] ? (q_ty ^ tmask) : q_ty;
  assign tile  = cfg.big_tiles ? (entry[9:0] + {5'b00000, ty_f[3], 3'b000, tx_f[3]})
                               : entry[9:0];

  // Plane byte addresses, all wrapping at 16 bits
  assign char_base = cfg.char_origin + {1'b0, tile, 5'b00000};
  assign p01       = char_base + {12'h000, ty_f[2:0], 1'b0};
  assign p23       = p01 + 16'd16;

  // Port A carries the map read or planes 0/1, port B planes 2/3
  assign addr_a     = (state == BK_TILE) ? p01 : op.addr;
  assign even_a_idx = addr_a[15:1] + BANK_ADDR_W'(addr_a[0]);
  assign odd_a_idx  = addr_a[15:1];
  assign even_b_idx = p23[15:1] + BANK_ADDR_W'(p23[0]);
  assign odd_b_idx  = p23[15:1];

  // Memory write and registered reads
  always_ff @(posedge clk) begin
    if (pop_write && !op.addr[0]) begin
      vram_even[op.addr[15:1]] <= op.data;
    end
    if (pop_write && op.addr[0]) begin
      vram_odd[op.addr[15:1]] <= op.data;
    end
    if (rd_a_en) begin
      rd_even_a <= vram_even[even_a_idx];
      rd_odd_a  <= vram_odd[odd_a_idx];
    end
    if (rd_b_en) begin
      rd_even_b <= vram_even[even_b_idx];
      rd_odd_b  <= vram_odd[odd_b_idx];
    end
  end

  // Capture per-query payload
  always_ff @(posedge clk) begin
    if (pop_query) begin
      map_lsb <= op.addr[0];
      q_tx    <= op.tx;
      q_ty    <= op.ty;
    end
    if (state == BK_TILE) begin
      grp       <= entry[12:10];
      col       <= tx_f[2:0];
      plane_lsb <= p01[0];
    end
    if (load_out) begin
      palette_index <= pix_index;
    end
  end

  // Gather one planar pixel, leftmost column in bit 7
  assign b0        = plane_lsb ? rd_odd_a  : rd_even_a;
  assign b1        = plane_lsb ? rd_even_a : rd_odd_a;
  assign b2        = plane_lsb ? rd_odd_b  : rd_even_b;
  assign b3        = plane_lsb ? rd_even_b : rd_odd_b;
  assign bit_sel   = ~col;
  assign pix       = {b3[bit_sel], b2[bit_sel], b1[bit_sel], b0[bit_sel]};
  assign pix_index = (pix == 4'h0) ? 7'd0 : {grp, pix};

endmodule

FILE: hdl/tilemap_background_pixel_fetch_core.sv
// ----------------------------------------------------------------------------
// tilemap_background_pixel_fetch_core
// Result: a query passes the queue slot, the map-entry read, the plane read
//   and the output register; a memory write gives no result.
// Throughput: a query issues as the previous result is loaded, set by the
//   dependent map-entry and plane reads; one write per cycle while idle.
// Reset: clears configuration, queue and sequencer; video memory is not
//   cleared and holds undefined data until written.
// ----------------------------------------------------------------------------
module tilemap_background_pixel_fetch_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [15:0] mem_address,
  input  logic [7:0]  mem_data,
  input  logic [7:0]  query_x,
  input  logic [7:0]  query_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  palette_index
);
  import tbpf_pkg::*;

  cfg_t          cfg;
  fetch_op_t     front_op;
  fetch_op_t     head_op;
  logic          head_valid;
  logic          head_ready;
  queue_status_t q_status;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_MAP_ORIGIN:  cfg.map_origin  <= cfg_data;
        CFG_MAP_WIDE:    cfg.map_wide    <= cfg_data[0];
        CFG_MAP_TALL:    cfg.map_tall    <= cfg_data[0];
        CFG_CHAR_ORIGIN: cfg.char_origin <= cfg_data;
        CFG_BIG_TILES:   cfg.big_tiles   <= cfg_data[0];
        CFG_SCROLL_X:    cfg.scroll_x    <= cfg_data[9:0];
        CFG_SCROLL_Y:    cfg.scroll_y    <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  tbpf_front u_front (
    .cfg         (cfg),
    .command     (command),
    .mem_address (mem_address),
    .mem_data    (mem_data),
    .query_x     (query_x),
    .query_y     (query_y),
    .op          (front_op)
  );

  tbpf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_op    (front_op),
    .pop_valid  (head_valid),
    .pop_ready  (head_ready),
    .pop_op     (head_op),
    .status     (q_status)
  );

  tbpf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .op_valid      (head_valid),
    .op_ready      (head_ready),
    .op            (head_op),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .palette_index (palette_index)
  );

  // Queue occupancy stays within its depth
  assert property (@(posedge clk) disable iff (rst)
    q_status.count <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  // An accepted transaction with no pop grows the queue by one
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !(head_valid && head_ready))
    |=> (q_status.count == $past(q_status.count) + 1'b1))
    else $error("queue count did not track a push");

  // Full queue refuses new transactions
  assert property (@(posedge clk) disable iff (rst)
    (q_status.count == QUEUE_CNT_W'(QUEUE_DEPTH)) |-> !in_ready)
    else $error("full queue accepted a transaction");

  // A transparent pixel carries no palette group
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((palette_index[3:0] != 4'h0) || (palette_index == 7'd0)))
    else $error("transparent pixel with nonzero group");

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the background tile pixel fetch core. Video memory
// is loaded with byte writes, then pixel queries are checked against a local
// prediction of the map lookup, flips, sub-tile selection and planar gather.
// Every byte a query touches is written first. Directed cases cover
// coordinate, scroll and register extremes, address wrap and flips. They are
// followed by back-pressure and randomized traffic under several settings.
// ----------------------------------------------------------------------------
module tb;
  import tbpf_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam logic [2:0]  CFG_UNUSED    = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        command = CMD_WRITE;
  logic [15:0] mem_address = '0;
  logic [7:0]  mem_data = '0;
  logic [7:0]  query_x = '0;
  logic [7:0]  query_y = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [6:0]  palette_index;

  // Shadow of the layer: configuration, video memory and which bytes are loaded
  cfg_t        layer_cfg = '0;
  logic [7:0]  vram_shadow [0:65535];
  bit          vram_known [0:65535];
  logic [6:0]  palette_expected [$];
  logic [6:0]  want_palette;

  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_off_request = 0;
  int unsigned rx_wait = 0;
  bit          calm = 1'b0;

  tilemap_background_pixel_fetch_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .mem_address  (mem_address),
    .mem_data     (mem_data),
    .query_x      (query_x),
    .query_y      (query_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .palette_index(palette_index)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= 100) $display("%0t ERROR: %s", $time, msg);
  endtask

  // Mostly short gaps, some medium, a few long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_coord();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    return 8'($urandom);
  endfunction

  function automatic logic [9:0] pick_scroll();
    int unsigned r;
    r = $urandom_range(0, 5);
    if (r == 0) return 10'd0;
    if (r == 1) return 10'h3ff;
    return 10'($urandom);
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    c.map_origin  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : {5'($urandom), 11'd0};
    c.map_wide    = 1'($urandom);
    c.map_tall    = 1'($urandom);
    c.char_origin = ($urandom_range(0, 3) == 0) ? 16'($urandom) : {3'($urandom), 13'd0};
    c.big_tiles   = 1'($urandom);
    c.scroll_x    = pick_scroll();
    c.scroll_y    = pick_scroll();
    return c;
  endfunction

  function automatic logic [15:0] map_word(bit vf, bit hf, logic [2:0] grp,
                                           logic [9:0] tile);
    return {vf, hf, 1'b0, grp, tile};
  endfunction

  // --------------------------------------------------------------------------
  // Pixel prediction
  // --------------------------------------------------------------------------

  // Scrolled position, wrapped to the map size in pixels
  function automatic void scroll_position(input logic [7:0] sx, input logic [7:0] sy,
                                          output int unsigned px, output int unsigned py);
    int unsigned span_x, span_y;
    span_x = (layer_cfg.map_wide ? 64 : 32) * (layer_cfg.big_tiles ? 16 : 8);
    span_y = (layer_cfg.map_tall ? 64 : 32) * (layer_cfg.big_tiles ? 16 : 8);
    px = (32'(sx) + 32'(layer_cfg.scroll_x)) & (span_x - 1);
    py = (32'(sy) + 32'(layer_cfg.scroll_y) + 1) & (span_y - 1);
  endfunction

  // Byte address of the map entry, picking the 2 KiB screen block
  function automatic logic [15:0] entry_address(int unsigned px, int unsigned py);
    int unsigned shift, mx, my, blk;
    shift = layer_cfg.big_tiles ? 4 : 3;
    mx = px >> shift;
    my = py >> shift;
    blk = 0;
    if (mx >= 32) begin
      blk += 1;
      mx -= 32;
    end
    if (my >= 32) begin
      blk += layer_cfg.map_wide ? 2 : 1;
      my -= 32;
    end
    return 16'(32'(layer_cfg.map_origin) + blk * 32'h800 + (my * 32 + mx) * 2);
  endfunction

  // Apply flips and sub-tile choice; give the plane 0/1 row address and bit
  function automatic void plane_address(input logic [15:0] entry, input int unsigned px,
                                        input int unsigned py, output logic [15:0] p01,
                                        output int unsigned bit_sel);
    int unsigned tsize, tx, ty, tile;
    tsize = layer_cfg.big_tiles ? 16 : 8;
    tx = px & (tsize - 1);
    ty = py & (tsize - 1);
    if (entry[ENTRY_HFLIP]) tx = tsize - 1 - tx;
    if (entry[ENTRY_VFLIP]) ty = tsize - 1 - ty;
    tile = 32'(entry[9:0]);
    if (layer_cfg.big_tiles) begin
      tile = (tile + (tx >> 3) + ((ty >> 3) << 4)) & 32'h3ff;
      tx &= 7;
      ty &= 7;
    end
    p01 = 16'(32'(layer_cfg.char_origin) + tile * 32 + ty * 2);
    bit_sel = 7 - tx;
  endfunction

  // Plane k lives at row offset 0, 1, 16, 17
  function automatic logic [15:0] plane_addr(logic [15:0] p01, int unsigned k);
    return p01 + ((k & 2) ? 16'd16 : 16'd0) + 16'(k & 1);
  endfunction

  function automatic logic [6:0] predict_palette(logic [7:0] sx, logic [7:0] sy);
    int unsigned px, py, bit_sel, value;
    logic [15:0] ea, ea_hi, p01, entry;
    scroll_position(sx, sy, px, py);
    ea = entry_address(px, py);
    ea_hi = ea + 16'd1;
    entry = {vram_shadow[ea_hi], vram_shadow[ea]};
    plane_address(entry, px, py, p01, bit_sel);
    value = 0;
    for (int k = 0; k < 4; k++)
      value |= 32'(vram_shadow[plane_addr(p01, k)][bit_sel]) << k;
    if (value == 0) return 7'd0;
    return 7'(32'(entry[12:10]) * 16 + value);
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  task automatic pause_sender(int unsigned n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Offer one transaction, hold it until taken, then update the shadow
  task automatic send_item(logic cmd, logic [15:0] addr, logic [7:0] data,
                           logic [7:0] sx, logic [7:0] sy);
    in_valid    <= 1'b1;
    command     <= cmd;
    mem_address <= addr;
    mem_data    <= data;
    query_x     <= sx;
    query_y     <= sy;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (cmd == CMD_WRITE) begin
      vram_shadow[addr] = data;
      vram_known[addr]  = 1'b1;
    end else begin
      palette_expected.push_back(predict_palette(sx, sy));
    end
    if (!calm && $urandom_range(0, 99) >= 60) pause_sender(gap_len());
  endtask

  task automatic write_byte(logic [15:0] addr, logic [7:0] data);
    send_item(CMD_WRITE, addr, data, 8'($urandom), 8'($urandom));
  endtask

  // Load a byte that is still unknown, and now and then refresh a known one
  task automatic fill_byte(logic [15:0] addr, int unsigned fresh_pct);
    if (!vram_known[addr] || $urandom_range(0, 99) < fresh_pct)
      write_byte(addr, 8'($urandom));
  endtask

  // Load the map entry and the four plane bytes a query reads, then query.
  // A plane byte that overlaps the entry is left alone so the entry holds.
  task automatic stage_query(logic [7:0] sx, logic [7:0] sy, bit directed,
                             logic [15:0] entry, logic [31:0] planes);
    int unsigned px, py, bit_sel;
    logic [15:0] ea, ea_hi, p01, pa;
    scroll_position(sx, sy, px, py);
    ea = entry_address(px, py);
    ea_hi = ea + 16'd1;
    if (directed) begin
      write_byte(ea, entry[7:0]);
      write_byte(ea_hi, entry[15:8]);
    end else begin
      fill_byte(ea, 25);
      fill_byte(ea_hi, 25);
    end
    plane_address({vram_shadow[ea_hi], vram_shadow[ea]}, px, py, p01, bit_sel);
    for (int k = 0; k < 4; k++) begin
      pa = plane_addr(p01, k);
      if (pa != ea && pa != ea_hi) begin
        if (directed) write_byte(pa, planes[8*k +: 8]);
        else fill_byte(pa, 25);
      end
    end
    send_item(CMD_QUERY, 16'($urandom), 8'($urandom), sx, sy);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    @(posedge clk);
    case (idx)
      CFG_MAP_ORIGIN:  layer_cfg.map_origin  = data;
      CFG_MAP_WIDE:    layer_cfg.map_wide    = data[0];
      CFG_MAP_TALL:    layer_cfg.map_tall    = data[0];
      CFG_CHAR_ORIGIN: layer_cfg.char_origin = data;
      CFG_BIG_TILES:   layer_cfg.big_tiles   = data[0];
      CFG_SCROLL_X:    layer_cfg.scroll_x    = data[9:0];
      CFG_SCROLL_Y:    layer_cfg.scroll_y    = data[9:0];
      default: ;
    endcase
  endtask

  // Write every register; unused upper bits carry junk that must be dropped
  task automatic load_config(cfg_t c, bit stray);
    write_reg(CFG_MAP_ORIGIN,  c.map_origin);
    write_reg(CFG_MAP_WIDE,    {15'($urandom), c.map_wide});
    write_reg(CFG_MAP_TALL,    {15'($urandom), c.map_tall});
    write_reg(CFG_CHAR_ORIGIN, c.char_origin);
    write_reg(CFG_BIG_TILES,   {15'($urandom), c.big_tiles});
    write_reg(CFG_SCROLL_X,    {6'($urandom), c.scroll_x});
    write_reg(CFG_SCROLL_Y,    {6'($urandom), c.scroll_y});
    if (stray) write_reg(CFG_UNUSED, 16'($urandom));
    cfg_write_en <= 1'b0;
    @(posedge clk);
  endtask

  // Stop sending, wait for every pending result, let trailing writes retire
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (palette_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver and checker
  // --------------------------------------------------------------------------

  // Stall at random, or for a requested stretch
  always @(posedge clk) begin
    if (hold_off_request != 0) begin
      rx_wait = hold_off_request;
      hold_off_request = 0;
    end
    if (rx_wait == 0 && !calm && $urandom_range(0, 99) < 15) rx_wait = gap_len();
    if (rx_wait != 0) begin
      out_ready <= 1'b0;
      rx_wait--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (palette_expected.size() == 0) begin
        report_mismatch($sformatf("palette_index %0d with no query pending", palette_index));
      end else begin
        want_palette = palette_expected.pop_front();
        if (palette_index !== want_palette)
          report_mismatch($sformatf("palette_index %0d, expected %0d",
                                    palette_index, want_palette));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset configuration: 32x32 map of 8 pixel tiles at address 0
  task automatic test_reset_defaults();
    stage_query(8'd0, 8'd0, 1'b1, map_word(0, 0, 3'd3, 10'd5), 32'hffffffff);
    stage_query(8'd255, 8'd255, 1'b1, map_word(0, 0, 3'd0, 10'd0), 32'h00000000);
    stage_query(8'd7, 8'd6, 1'b1, map_word(0, 0, 3'd7, 10'h3ff), 32'h01010101);
  endtask

  // Each flip combination on an asymmetric plane pattern
  task automatic test_flips();
    cfg_t c;
    c = '0;
    c.map_origin  = 16'h2000;
    c.char_origin = 16'h4000;
    wait_idle();
    load_config(c, 1'b0);
    stage_query(8'd2, 8'd4, 1'b1, map_word(0, 0, 3'd1, 10'd9), 32'h5ac30180);
    stage_query(8'd2, 8'd4, 1'b1, map_word(0, 1, 3'd2, 10'd9), 32'h5ac30180);
    stage_query(8'd2, 8'd4, 1'b1, map_word(1, 0, 3'd4, 10'd9), 32'h5ac30180);
    stage_query(8'd2, 8'd4, 1'b1, map_word(1, 1, 3'd6, 10'd9), 32'h5ac30180);
  endtask

  // 16 pixel tiles on a 64x64 map; tile number plus sub-tile wraps at 10 bits
  task automatic test_big_tiles();
    cfg_t c;
    c = '0;
    c.map_wide   = 1'b1;
    c.map_tall   = 1'b1;
    c.big_tiles  = 1'b1;
    c.map_origin = 16'h8000;
    wait_idle();
    load_config(c, 1'b0);
    stage_query(8'd9, 8'd7, 1'b1, map_word(0, 0, 3'd5, 10'h3ff), 32'hffffffff);
    stage_query(8'd3, 8'd2, 1'b1, map_word(1, 1, 3'd2, 10'h3f8), 32'h0f0f0f0f);
    stage_query(8'd200, 8'd250, 1'b1, map_word(0, 1, 3'd7, 10'h3ef), 32'h3c3c3c3c);
  endtask

  // Scroll past the map edge with a tall, narrow map; planes wrap past 0xffff
  task automatic test_scroll_wrap();
    cfg_t c;
    c = '0;
    c.map_tall    = 1'b1;
    c.char_origin = 16'hfff0;
    c.scroll_x    = 10'd1000;
    c.scroll_y    = 10'h3ff;
    wait_idle();
    load_config(c, 1'b0);
    stage_query(8'd255, 8'd6, 1'b1, map_word(0, 0, 3'd3, 10'd0), 32'h81422418);
    stage_query(8'd30, 8'd255, 1'b0, 16'h0, 32'h0);
    stage_query(8'd0, 8'd128, 1'b0, 16'h0, 32'h0);
  endtask

  // Every register at its top value; map entry straddles 0xffff; index 7 ignored
  task automatic test_register_extremes();
    cfg_t c;
    c = '1;
    wait_idle();
    load_config(c, 1'b1);
    stage_query(8'd1, 8'd0, 1'b1, map_word(1, 1, 3'd7, 10'h3ff), 32'hffffffff);
    stage_query(8'd255, 8'd255, 1'b1, map_word(0, 0, 3'd1, 10'h155), 32'h5a5aa5a5);
    stage_query(8'd0, 8'd0, 1'b1, map_word(1, 0, 3'd0, 10'h2aa), 32'hc0300c03);
  endtask

  // Hold the result side off while queries keep coming, then drain
  task automatic test_backpressure();
    wait_idle();
    calm = 1'b1;
    hold_off_request = 400;
    repeat (24) stage_query(pick_coord(), pick_coord(), 1'b0, 16'h0, 32'h0);
    calm = 1'b0;
    wait_idle();
  endtask

  // Phases of random traffic, each under its own configuration
  task automatic test_random_traffic(int unsigned item_goal);
    cfg_t c;
    int unsigned phase, stop_at;
    phase = 0;
    while (items_sent < item_goal) begin
      wait_idle();
      case (phase)
        0:       c = '1;
        1:       c = '0;
        default: c = random_config();
      endcase
      load_config(c, phase == 2);
      calm = (phase % 4 == 3);
      stop_at = items_sent + 100;
      if (stop_at > item_goal) stop_at = item_goal;
      while (items_sent < stop_at) begin
        if ($urandom_range(0, 99) < 82)
          stage_query(pick_coord(), pick_coord(), 1'b0, 16'h0, 32'h0);
        else
          write_byte(16'($urandom), 8'($urandom));
      end
      calm = 1'b0;
      phase++;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_flips();
    test_big_tiles();
    test_scroll_wrap();
    test_register_extremes();
    test_backpressure();
    test_random_traffic(1150);
    wait_idle();
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
